// ===== hdl/line_position_estimator_unit_defines.svh =====
// ----------------------------------------------------------------------------
// Line position estimator assertion macros
// Shared assertion wrappers; define ASSERT_OFF to compile them out.
// ----------------------------------------------------------------------------
`ifndef LINE_POSITION_ESTIMATOR_UNIT_DEFINES_SVH
`define LINE_POSITION_ESTIMATOR_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF

// Property must hold at every clock edge outside reset.
`define LPE_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error(msg);

// Condition must never be true outside reset.
`define LPE_ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error(msg);

`else

`define LPE_ASSERT(lbl, clk, rstn, prop, msg)

`define LPE_ASSERT_NEVER(lbl, clk, rstn, cond, msg)

`endif

`endif

// ===== hdl/lpe_pkg.sv =====
// ----------------------------------------------------------------------------
// Line position estimator package
// Sizes, payload types and codes shared by the estimator and its divider.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lpe_pkg;

  localparam int unsigned SENSOR_COUNT = 8;
  localparam int unsigned SAMPLE_BITS  = 10;

  // Configuration register widths
  localparam int unsigned CONTRAST_BITS = 10;
  localparam int unsigned EDGE_BITS     = 10;
  localparam int unsigned SIGNAL_BITS   = 13;
  localparam int unsigned CFG_BITS      = 13;
  localparam int unsigned CFG_IDX_BITS  = 2;

  localparam logic [CONTRAST_BITS-1:0] CONTRAST_RESET = CONTRAST_BITS'(200);
  localparam logic [EDGE_BITS-1:0]     EDGE_RESET     = EDGE_BITS'(100);
  localparam logic [SIGNAL_BITS-1:0]   SIGNAL_RESET   = SIGNAL_BITS'(100);

  // Result position
  localparam int unsigned POS_BITS = 8;
  localparam int unsigned QUO_BITS = POS_BITS - 1;
  localparam logic signed [POS_BITS-1:0] POS_EDGE_RIGHT = POS_BITS'(127);
  localparam logic signed [POS_BITS-1:0] POS_EDGE_LEFT  = -POS_EDGE_RIGHT;

  // Datapath widths
  localparam int unsigned CNT_BITS  = $clog2(SENSOR_COUNT);
  localparam int unsigned SUM_BITS  = SAMPLE_BITS + $clog2(SENSOR_COUNT);
  localparam int unsigned WGT_BITS  = $clog2(SENSOR_COUNT) + 1;
  localparam int unsigned DEN_BITS  = SUM_BITS + $clog2(SENSOR_COUNT);
  localparam int unsigned WSUM_BITS = DEN_BITS + 1;
  localparam int unsigned NUM_BITS  = DEN_BITS + QUO_BITS;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_MIN_CONTRAST = 2'd0,
    CFG_EDGE_DIFF    = 2'd1,
    CFG_MIN_SIGNAL   = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    SRC_CENTROID     = 2'd0,
    SRC_LOW_CONTRAST = 2'd1,
    SRC_EDGE         = 2'd2,
    SRC_LOW_SIGNAL   = 2'd3
  } src_e;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] sample_0;
    logic [SAMPLE_BITS-1:0] sample_1;
    logic [SAMPLE_BITS-1:0] sample_2;
    logic [SAMPLE_BITS-1:0] sample_3;
    logic [SAMPLE_BITS-1:0] sample_4;
    logic [SAMPLE_BITS-1:0] sample_5;
    logic [SAMPLE_BITS-1:0] sample_6;
    logic [SAMPLE_BITS-1:0] sample_7;
  } scan_t;

  typedef struct packed {
    logic signed [POS_BITS-1:0] line_position;
    src_e                       position_source;
  } result_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// ===== hdl/lpe_div.sv =====
// ----------------------------------------------------------------------------
// Line position estimator divider
// Restoring divider, one quotient bit per cycle, for quotients below 2**QUO_BITS.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "line_position_estimator_unit_defines.svh"

module lpe_div
  import lpe_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [NUM_BITS-1:0] num_i,
  input  logic [DEN_BITS-1:0] den_i,
  output div_stat_t           stat_o,
  output logic [QUO_BITS-1:0] quo_o
);

  localparam int unsigned STEP_BITS = $clog2(QUO_BITS);

  logic                 busy_q;
  logic                 done_q;
  logic [STEP_BITS-1:0] step_q;
  logic [NUM_BITS-1:0]  rem_q;
  logic [NUM_BITS-1:0]  dvs_q;
  logic [QUO_BITS-1:0]  quo_q;
  logic                 fits;
  logic                 last_step;

  assign fits      = (rem_q >= dvs_q);
  assign last_step = (step_q == STEP_BITS'(QUO_BITS - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + 1'b1;
        if (last_step) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= num_i;
      // align the divisor with the top quotient bit
      dvs_q <= NUM_BITS'({den_i, {(QUO_BITS - 1){1'b0}}});
      quo_q <= '0;
    end else if (busy_q) begin
      if (fits) begin
        rem_q <= rem_q - dvs_q;
      end
      dvs_q <= dvs_q >> 1;
      quo_q <= {quo_q[QUO_BITS-2:0], fits};
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quo_o       = quo_q;

  `LPE_ASSERT_NEVER(a_start_while_busy, clk_i, rst_ni, start_i && busy_q,
                    "divider restarted while busy")
  `LPE_ASSERT(a_rem_bound, clk_i, rst_ni, busy_q |-> ({1'b0, rem_q} < {dvs_q, 1'b0}),
              "partial remainder out of range, quotient overflow")
  `LPE_ASSERT(a_done_after_busy, clk_i, rst_ni, done_q |-> ($past(busy_q) && !busy_q),
              "done without a finished division")

endmodule

// ===== hdl/line_position_estimator_unit.sv =====
// ----------------------------------------------------------------------------
// Line position estimator
// Weighted-centroid line position from one scan of SENSOR_COUNT samples.
// ----------------------------------------------------------------------------
// Usage: present a scan on in_data_i with in_valid_i; it is taken when
// in_stall_o is low. The result item appears on out_data_o with out_valid_o
// and is held until out_stall_i is low at a clock edge.
// Timing: the scan is walked one sensor per cycle twice, once for min/max and
// once for the weighted sums, then a restoring divider yields one quotient
// bit per cycle. Low-contrast and edge results leave after the first pass,
// low-signal results after the second, and computed centroids after the
// divide. One scan is in work at a time; the next is taken the cycle after
// the result enters the output register, so a stalled result does not block
// the following scan's work, only its delivery.
// Reset: thresholds return to 200 / 100 / 100, the held position to zero and
// the output register empties. Configuration writes go to cfg_idx_i and take
// effect at once; indexes past the list are ignored.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "line_position_estimator_unit_defines.svh"

module line_position_estimator_unit
  import lpe_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0] cfg_idx_i,
  input  logic [CFG_BITS-1:0]     cfg_data_i,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  scan_t                   in_data_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output result_t                 out_data_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_CHECK,
    ST_ACCUM,
    ST_TEST,
    ST_DIVIDE,
    ST_FINISH
  } state_e;

  state_e                     state_q;
  logic [CNT_BITS-1:0]        cnt_q;
  logic                       out_valid_q;
  logic signed [POS_BITS-1:0] held_q;
  logic [CONTRAST_BITS-1:0]   contrast_q;
  logic [EDGE_BITS-1:0]       edge_thr_q;
  logic [SIGNAL_BITS-1:0]     signal_q;

  logic [SAMPLE_BITS-1:0]     samp_q [SENSOR_COUNT];
  logic [SAMPLE_BITS-1:0]     min_q;
  logic [SAMPLE_BITS-1:0]     max_q;
  logic [SUM_BITS-1:0]        sum_q;
  logic signed [WSUM_BITS-1:0] wsum_q;
  logic signed [POS_BITS-1:0] pos_q;
  src_e                       src_q;
  result_t                    out_q;

  logic                       in_acc;
  logic                       out_take;
  logic                       out_load;
  logic                       cnt_last;
  logic [SAMPLE_BITS-1:0]     head;
  logic [SAMPLE_BITS-1:0]     nrm;
  logic [SAMPLE_BITS-1:0]     spread;
  logic                       low_contrast;
  logic                       left_edge;
  logic                       right_edge;
  logic                       low_signal;
  logic signed [WGT_BITS-1:0] wgt;
  logic signed [WSUM_BITS-1:0] prod;
  logic                       wsum_neg;
  logic [DEN_BITS-1:0]        mag;
  logic [NUM_BITS-1:0]        div_num;
  logic [DEN_BITS-1:0]        div_den;
  logic                       div_start;
  div_stat_t                  div_stat;
  logic [QUO_BITS-1:0]        div_quo;
  logic signed [POS_BITS-1:0] quo_pos;

  assign in_acc   = in_valid_i && (state_q == ST_IDLE);
  assign out_take = out_valid_q && !out_stall_i;
  assign out_load = (state_q == ST_FINISH) && (!out_valid_q || !out_stall_i);
  assign cnt_last = (cnt_q == CNT_BITS'(SENSOR_COUNT - 1));

  assign head   = samp_q[0];
  assign nrm    = head - min_q;
  assign spread = max_q - min_q;

  assign low_contrast = (spread < contrast_q);
  // an end sample equal to the maximum is never below its neighbor
  assign left_edge  = (samp_q[0] == max_q) && ((samp_q[0] - samp_q[1]) >= edge_thr_q);
  assign right_edge = (samp_q[SENSOR_COUNT-1] == max_q) &&
                      ((samp_q[SENSOR_COUNT-1] - samp_q[SENSOR_COUNT-2]) >= edge_thr_q);
  assign low_signal = (sum_q < signal_q) || (sum_q == '0);

  // weight 2*i - (N-1) for the sensor now at the head
  assign wgt  = WGT_BITS'({cnt_q, 1'b0}) - WGT_BITS'(SENSOR_COUNT - 1);
  assign prod = WSUM_BITS'(wgt) * WSUM_BITS'($signed({1'b0, nrm}));

  assign wsum_neg  = wsum_q[WSUM_BITS-1];
  assign mag       = DEN_BITS'(wsum_neg ? -wsum_q : wsum_q);
  // 127 * |wsum| as a shift and subtract
  assign div_num   = NUM_BITS'({mag, {QUO_BITS{1'b0}}}) - NUM_BITS'(mag);
  assign div_den   = DEN_BITS'(sum_q) * DEN_BITS'(SENSOR_COUNT - 1);
  assign div_start = (state_q == ST_TEST) && !low_signal;
  assign quo_pos   = POS_BITS'(div_quo);

  lpe_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .stat_o  (div_stat),
    .quo_o   (div_quo)
  );

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      contrast_q <= CONTRAST_RESET;
      edge_thr_q <= EDGE_RESET;
      signal_q   <= SIGNAL_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_MIN_CONTRAST: contrast_q <= cfg_data_i[CONTRAST_BITS-1:0];
        CFG_EDGE_DIFF:    edge_thr_q <= cfg_data_i[EDGE_BITS-1:0];
        CFG_MIN_SIGNAL:   signal_q   <= cfg_data_i[SIGNAL_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer, output valid and held position
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      held_q      <= '0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_take) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            state_q <= ST_SCAN;
            cnt_q   <= '0;
          end
        end
        ST_SCAN: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_last) begin
            cnt_q   <= '0;
            state_q <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          if (low_contrast || left_edge || right_edge) begin
            state_q <= ST_FINISH;
          end else begin
            state_q <= ST_ACCUM;
          end
        end
        ST_ACCUM: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_last) begin
            cnt_q   <= '0;
            state_q <= ST_TEST;
          end
        end
        ST_TEST: begin
          state_q <= low_signal ? ST_FINISH : ST_DIVIDE;
        end
        ST_DIVIDE: begin
          if (div_stat.done) begin
            state_q <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (out_load) begin
            state_q <= ST_IDLE;
            if (src_q inside {SRC_EDGE, SRC_CENTROID}) begin
              held_q <= pos_q;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          samp_q[0] <= in_data_i.sample_0;
          samp_q[1] <= in_data_i.sample_1;
          samp_q[2] <= in_data_i.sample_2;
          samp_q[3] <= in_data_i.sample_3;
          samp_q[4] <= in_data_i.sample_4;
          samp_q[5] <= in_data_i.sample_5;
          samp_q[6] <= in_data_i.sample_6;
          samp_q[7] <= in_data_i.sample_7;
        end
      end
      ST_SCAN: begin
        if (cnt_q == '0) begin
          min_q <= head;
          max_q <= head;
        end else begin
          if (head < min_q) min_q <= head;
          if (head > max_q) max_q <= head;
        end
        // rotate one sensor toward the head; a full pass restores the order
        for (int i = 0; i < SENSOR_COUNT - 1; i++) begin
          samp_q[i] <= samp_q[i+1];
        end
        samp_q[SENSOR_COUNT-1] <= head;
      end
      ST_CHECK: begin
        sum_q  <= '0;
        wsum_q <= '0;
        if (low_contrast) begin
          pos_q <= held_q;
          src_q <= SRC_LOW_CONTRAST;
        end else if (left_edge) begin
          pos_q <= POS_EDGE_LEFT;
          src_q <= SRC_EDGE;
        end else begin
          pos_q <= POS_EDGE_RIGHT;
          src_q <= SRC_EDGE;
        end
      end
      ST_ACCUM: begin
        sum_q  <= sum_q + SUM_BITS'(nrm);
        wsum_q <= wsum_q + prod;
        for (int i = 0; i < SENSOR_COUNT - 1; i++) begin
          samp_q[i] <= samp_q[i+1];
        end
        samp_q[SENSOR_COUNT-1] <= head;
      end
      ST_TEST: begin
        pos_q <= held_q;
        src_q <= SRC_LOW_SIGNAL;
      end
      ST_DIVIDE: begin
        if (div_stat.done) begin
          pos_q <= wsum_neg ? -quo_pos : quo_pos;
          src_q <= SRC_CENTROID;
        end
      end
      default: ;
    endcase

    if (out_load) begin
      out_q.line_position   <= pos_q;
      out_q.position_source <= src_q;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `LPE_ASSERT(a_held_only_on_load, clk_i, rst_ni, !$stable(held_q) |-> $past(out_load),
              "held position changed outside a result load")
  `LPE_ASSERT(a_divide_tracks_div, clk_i, rst_ni,
              (state_q == ST_DIVIDE) |-> (div_stat.busy || div_stat.done),
              "waiting on an idle divider")
  `LPE_ASSERT(a_edge_is_full_scale, clk_i, rst_ni,
              (out_valid_q && (out_q.position_source == SRC_EDGE)) |->
              ((out_q.line_position == POS_EDGE_LEFT) ||
               (out_q.line_position == POS_EDGE_RIGHT)),
              "edge result not at full scale")

endmodule

// ===== verif/tb_line_position_estimator_unit.sv =====
// ----------------------------------------------------------------------------
// Line position estimator testbench
// Drives sensor scans through the valid/stall input channel, predicts each
// line position from its own copy of the thresholds and the held position,
// and checks every result item in order while both channels idle at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_line_position_estimator_unit;
  import lpe_pkg::*;

  localparam int SENSORS      = SENSOR_COUNT;
  localparam int SAMPLE_MAX   = (1 << SAMPLE_BITS) - 1;
  localparam int IDLE_LIMIT   = 2000;
  localparam int DRAIN_CYCLES = 40;
  localparam int MAX_PRINTS   = 100;

  localparam logic [CFG_IDX_BITS-1:0] CFG_UNUSED = 2'd3;

  localparam int STALL_NONE  = 0;
  localparam int STALL_LIGHT = 1;
  localparam int STALL_HEAVY = 2;

  typedef enum int {
    SCAN_LINE, SCAN_UNIFORM, SCAN_FLAT, SCAN_EDGE, SCAN_FAINT, SCAN_EXTREME
  } scan_kind_e;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    cfg_we_i = 1'b0;
  logic [CFG_IDX_BITS-1:0] cfg_idx_i = '0;
  logic [CFG_BITS-1:0]     cfg_data_i = '0;
  logic                    in_valid_i = 1'b0;
  logic                    in_stall_o;
  scan_t                   in_data_i = '0;
  logic                    out_valid_o;
  logic                    out_stall_i = 1'b0;
  result_t                 out_data_o;

  line_position_estimator_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  // Shadow copy of the block's registers and state
  int                         contrast_thr = 200;
  int                         edge_thr     = 100;
  int                         signal_thr   = 100;
  logic signed [POS_BITS-1:0] held_pos     = '0;

  result_t pending_positions [$];
  int      mismatch_count = 0;
  int      idle_cycles    = 0;

  // Pacing of both channels
  int          gap_max    = 0;
  int          burst_max  = 1;
  int          burst_left = 0;
  int          stall_mode = STALL_NONE;
  logic [15:0] stall_pattern = '0;
  int          stall_tick = 0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic result_t predict_position(input scan_t sc);
    int      s [SENSORS];
    int      lo;
    int      hi;
    int      sum;
    int      wsum;
    int      mag;
    int      q;
    result_t r;
    s[0] = sc.sample_0;
    s[1] = sc.sample_1;
    s[2] = sc.sample_2;
    s[3] = sc.sample_3;
    s[4] = sc.sample_4;
    s[5] = sc.sample_5;
    s[6] = sc.sample_6;
    s[7] = sc.sample_7;
    lo = s[0];
    hi = s[0];
    for (int i = 1; i < SENSORS; i++) begin
      if (s[i] < lo) lo = s[i];
      if (s[i] > hi) hi = s[i];
    end
    if (hi - lo < contrast_thr) begin
      r.line_position   = held_pos;
      r.position_source = SRC_LOW_CONTRAST;
      return r;
    end
    // left end wins when both ends qualify
    if (s[0] == hi && s[0] - s[1] >= edge_thr) begin
      held_pos          = POS_EDGE_LEFT;
      r.line_position   = held_pos;
      r.position_source = SRC_EDGE;
      return r;
    end
    if (s[SENSORS-1] == hi && s[SENSORS-1] - s[SENSORS-2] >= edge_thr) begin
      held_pos          = POS_EDGE_RIGHT;
      r.line_position   = held_pos;
      r.position_source = SRC_EDGE;
      return r;
    end
    sum  = 0;
    wsum = 0;
    for (int i = 0; i < SENSORS; i++) begin
      sum  += s[i] - lo;
      wsum += (2 * i - (SENSORS - 1)) * (s[i] - lo);
    end
    // a zero sum never reaches the divide
    if (sum < signal_thr || sum == 0) begin
      r.line_position   = held_pos;
      r.position_source = SRC_LOW_SIGNAL;
      return r;
    end
    mag = (wsum < 0) ? -wsum : wsum;
    q   = (127 * mag) / ((SENSORS - 1) * sum);
    if (q > 127) q = 127;
    held_pos          = POS_BITS'((wsum < 0) ? -q : q);
    r.line_position   = held_pos;
    r.position_source = SRC_CENTROID;
    return r;
  endfunction

  function automatic scan_t make_scan();
    int         v [SENSORS];
    int         b;
    int         amp;
    int         c2;
    int         w;
    int         d;
    int         noise;
    int         side;
    int         pick;
    scan_kind_e kind;
    scan_t      sc;
    pick = $urandom_range(0, 99);
    if (pick < 45)      kind = SCAN_LINE;
    else if (pick < 60) kind = SCAN_UNIFORM;
    else if (pick < 70) kind = SCAN_FLAT;
    else if (pick < 80) kind = SCAN_EDGE;
    else if (pick < 90) kind = SCAN_FAINT;
    else                kind = SCAN_EXTREME;
    b     = $urandom_range(0, 400);
    amp   = $urandom_range(0, SAMPLE_MAX - b);
    c2    = $urandom_range(0, 2 * (SENSORS - 1));
    w     = $urandom_range(1, 8);
    noise = $urandom_range(0, 15);
    for (int i = 0; i < SENSORS; i++) begin
      case (kind)
        SCAN_LINE: begin
          d    = (2 * i > c2) ? 2 * i - c2 : c2 - 2 * i;
          v[i] = (d < w) ? b + amp * (w - d) / w : b;
          v[i] += $urandom_range(0, noise);
        end
        SCAN_UNIFORM: v[i] = $urandom_range(0, SAMPLE_MAX);
        SCAN_FLAT:    v[i] = amp + $urandom_range(0, 40);
        SCAN_EDGE:    v[i] = $urandom_range(0, 600);
        SCAN_FAINT:   v[i] = b;
        default:      v[i] = $urandom_range(0, 1) ? SAMPLE_MAX : 0;
      endcase
      if (v[i] > SAMPLE_MAX) v[i] = SAMPLE_MAX;
    end
    side = $urandom_range(0, 1) ? SENSORS - 1 : 0;
    if (kind == SCAN_EDGE) begin
      v[side] = $urandom_range(600, SAMPLE_MAX);
      // sometimes pull the neighbor close to the end sample
      if ($urandom_range(0, 2) == 0)
        v[side == 0 ? 1 : SENSORS - 2] = v[side] - $urandom_range(0, 150);
      if ($urandom_range(0, 4) == 0) v[SENSORS - 1 - side] = v[side];
    end else if (kind == SCAN_FAINT) begin
      c2    = $urandom_range(0, SENSORS - 1);
      v[c2] = b + $urandom_range(0, 300);
    end
    sc.sample_0 = SAMPLE_BITS'(v[0]);
    sc.sample_1 = SAMPLE_BITS'(v[1]);
    sc.sample_2 = SAMPLE_BITS'(v[2]);
    sc.sample_3 = SAMPLE_BITS'(v[3]);
    sc.sample_4 = SAMPLE_BITS'(v[4]);
    sc.sample_5 = SAMPLE_BITS'(v[5]);
    sc.sample_6 = SAMPLE_BITS'(v[6]);
    sc.sample_7 = SAMPLE_BITS'(v[7]);
    return sc;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_PRINTS) $display("ERROR @%0t: %s", $realtime, msg);
  endtask

  // Send one scan item; hold it until taken, then maybe open a gap.
  task automatic send_scan(input scan_t sc);
    in_valid_i <= 1'b1;
    in_data_i  <= sc;
    do @(posedge clk_i); while (in_stall_o);
    pending_positions.push_back(predict_position(sc));
    if (gap_max > 0) begin
      if (burst_left > 0) burst_left--;
      if (burst_left == 0) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, gap_max)) @(posedge clk_i);
        burst_left = $urandom_range(1, burst_max);
      end
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input int value);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= CFG_BITS'(value);
    @(posedge clk_i);
    case (idx)
      CFG_MIN_CONTRAST: contrast_thr = value & ((1 << CONTRAST_BITS) - 1);
      CFG_EDGE_DIFF:    edge_thr     = value & ((1 << EDGE_BITS) - 1);
      CFG_MIN_SIGNAL:   signal_thr   = value & ((1 << SIGNAL_BITS) - 1);
      default: ;
    endcase
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Drop valid and wait until every expected result item has come back.
  task automatic drain();
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (pending_positions.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic set_pace(input int gap, input int burst, input int stall);
    gap_max    = gap;
    burst_max  = burst;
    stall_mode = stall;
  endtask

  task automatic test_directed_cases();
    set_pace(0, 1, STALL_NONE);
    // reset thresholds 200 / 100 / 100
    send_scan('{10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0});
    send_scan('{10'd1023, 10'd1023, 10'd1023, 10'd1023, 10'd1023, 10'd1023, 10'd1023,
                10'd1023});
    send_scan('{10'd0, 10'd0, 10'd0, 10'd1023, 10'd1023, 10'd0, 10'd0, 10'd0});
    send_scan('{10'd1023, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0});
    send_scan('{10'd100, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0});
    send_scan('{10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd1023});
    send_scan('{10'd1023, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd1023});
    send_scan('{10'd1023, 10'd1000, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0});
    send_scan('{10'h2AA, 10'h155, 10'h2AA, 10'h155, 10'h2AA, 10'h155, 10'h2AA, 10'h155});
    send_scan('{10'h155, 10'h2AA, 10'h155, 10'h2AA, 10'h155, 10'h2AA, 10'h155, 10'h2AA});
    send_scan('{10'd0, 10'd0, 10'd1023, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0});
    send_scan('{10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd900, 10'd1023, 10'd0});
    drain();
    // zero contrast and signal thresholds: a flat scan has a zero sum
    write_reg(CFG_MIN_CONTRAST, 0);
    write_reg(CFG_EDGE_DIFF, 1);
    write_reg(CFG_MIN_SIGNAL, 0);
    send_scan('{10'd500, 10'd500, 10'd500, 10'd500, 10'd500, 10'd500, 10'd500, 10'd500});
    send_scan('{10'd0, 10'd1, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0});
    drain();
    // zero edge threshold: an end equal to its neighbor still qualifies
    write_reg(CFG_EDGE_DIFF, 0);
    write_reg(CFG_MIN_SIGNAL, 5000);
    send_scan('{10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd800, 10'd800});
    send_scan('{10'd0, 10'd0, 10'd300, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0});
    send_scan('{10'd800, 10'd800, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0});
    drain();
  endtask

  task automatic test_register_masking();
    set_pace(0, 1, STALL_NONE);
    // upper data bits fall away on the 10-bit registers
    write_reg(CFG_MIN_CONTRAST, (1 << CFG_BITS) - 1);
    write_reg(CFG_EDGE_DIFF, (1 << CFG_BITS) - 1);
    write_reg(CFG_MIN_SIGNAL, (1 << CFG_BITS) - 1);
    write_reg(CFG_UNUSED, 0);
    send_scan('{10'd1023, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0});
    send_scan('{10'd0, 10'd1023, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0});
    send_scan('{10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd1022, 10'd1023});
    send_scan('{10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd1023});
    drain();
  endtask

  task automatic test_throughput();
    write_reg(CFG_MIN_CONTRAST, 150);
    write_reg(CFG_EDGE_DIFF, 80);
    write_reg(CFG_MIN_SIGNAL, 300);
    set_pace(0, 1, STALL_NONE);
    repeat (150) send_scan(make_scan());
    drain();
    set_pace(0, 1, STALL_HEAVY);
    repeat (150) send_scan(make_scan());
    drain();
  endtask

  task automatic test_random_settings();
    int c;
    int e;
    int g;
    int pick;
    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0: begin c = 200;  e = 100;  g = 100;  end
        1: begin c = 0;    e = 0;    g = 0;    end
        2: begin c = 1023; e = 1023; g = 8184; end
        default: begin
          pick = $urandom_range(0, 9);
          c = (pick == 0) ? 0 : (pick == 1) ? 1023 : $urandom_range(0, 400);
          pick = $urandom_range(0, 9);
          e = (pick == 0) ? 0 : (pick == 1) ? 1023 : $urandom_range(0, 300);
          pick = $urandom_range(0, 9);
          g = (pick == 0) ? 0 : (pick == 1) ? 8184 : $urandom_range(0, 2500);
        end
      endcase
      // stray bits above the 10-bit fields must be ignored
      write_reg(CFG_MIN_CONTRAST, c | ($urandom_range(0, 7) << CONTRAST_BITS));
      write_reg(CFG_EDGE_DIFF, e | ($urandom_range(0, 7) << EDGE_BITS));
      write_reg(CFG_MIN_SIGNAL, g);
      case (phase % 4)
        0: set_pace(6, 8, STALL_LIGHT);
        1: set_pace(30, 3, STALL_HEAVY);
        2: set_pace(0, 1, STALL_LIGHT);
        default: set_pace(12, 1, STALL_NONE);
      endcase
      repeat (175) send_scan(make_scan());
      drain();
    end
  endtask

  // Result checker and receiver stall pattern
  always @(posedge clk_i) begin
    result_t exp_res;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_positions.size() == 0) begin
        report_mismatch($sformatf("result item with nothing expected: pos %0d src %0d",
                                  out_data_o.line_position, out_data_o.position_source));
      end else begin
        exp_res = pending_positions.pop_front();
        if (out_data_o.line_position !== exp_res.line_position)
          report_mismatch($sformatf("line_position %0d, expected %0d",
                                    out_data_o.line_position, exp_res.line_position));
        if (out_data_o.position_source !== exp_res.position_source)
          report_mismatch($sformatf("position_source %0d, expected %0d",
                                    out_data_o.position_source, exp_res.position_source));
      end
    end
    stall_tick++;
    if (stall_tick % 64 == 0) stall_pattern = 16'($urandom);
    else stall_pattern = {stall_pattern[0], stall_pattern[15:1]};
    case (stall_mode)
      STALL_LIGHT: out_stall_i <= stall_pattern[0] & stall_pattern[1];
      STALL_HEAVY: out_stall_i <= stall_pattern[0];
      default:     out_stall_i <= 1'b0;
    endcase
  end

  // Watchdog: end the run when neither channel moves for too long
  always @(posedge clk_i) begin
    if (!rst_ni || cfg_we_i || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles = 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb_line_position_estimator_unit NOT OK");
      $finish;
    end else begin
      idle_cycles++;
    end
  end

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);
    test_directed_cases();
    test_register_masking();
    test_throughput();
    test_random_settings();
    drain();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (pending_positions.size() != 0)
      report_mismatch($sformatf("%0d result items never arrived", pending_positions.size()));
    if (mismatch_count == 0) begin
      $display("tb_line_position_estimator_unit OK");
    end else begin
      $display("tb_line_position_estimator_unit NOT OK");
    end
    $finish;
  end

endmodule
